/* rtl/yuv2bgr_pkg.sv */
// shared types and constants of the yuv420 pixel pair to bgr converter
`timescale 1ns / 1ps

package yuv2bgr_pkg;

    localparam logic CSET_SEMI_PLANAR = 1'b0;
    localparam logic CSET_PLANAR      = 1'b1;

    // coefficients in ten-thousandths
    localparam longint TT_R_SEMI   = 64'd14075;
    localparam longint TT_GU_SEMI  = 64'd3455;
    localparam longint TT_GV_SEMI  = 64'd7169;
    localparam longint TT_B_SEMI   = 64'd17790;
    localparam longint TT_R_PLANAR  = 64'd14022;
    localparam longint TT_GU_PLANAR = 64'd3456;
    localparam longint TT_GV_PLANAR = 64'd7145;
    localparam longint TT_B_PLANAR  = 64'd17710;
    localparam longint TT_ONE       = 64'd10000;
    localparam longint TT_HALF      = 64'd5000;

    localparam int CHAN_MAX = 255;

    typedef struct packed {
        logic [7:0] chroma_red;
        logic [7:0] chroma_blue;
        logic [7:0] luma_right;
        logic [7:0] luma_left;
    } pixel_pair_t;

    typedef struct packed {
        logic [7:0] red_right;
        logic [7:0] green_right;
        logic [7:0] blue_right;
        logic [7:0] red_left;
        logic [7:0] green_left;
        logic [7:0] blue_left;
    } bgr_pair_t;

endpackage

/* rtl/yuv420_pixel_pair_to_bgr_top.sv */
// top level of the yuv420 pixel pair to bgr converter
//
//   port group   direction  content
//   s_*          in         one pixel pair word: two luma, shared u and v
//   m_*          out        one bgr word for both pixels
//   cfg_*        in         coefficient set select, 0 semi-planar, 1 planar
//
// one word per cycle while m_tready stays high; each word passes the product, sum and clamp stage registers in order;
// up to three words in flight; ready is combinational back through all stages,
// so s_tready falls only while all three stages hold a word and m_tready is low
// synchronous active-low reset empties the pipe and selects the semi-planar set
// cfg_ready is always high; write it only while the pipe is empty
`timescale 1ns / 1ps

module yuv420_pixel_pair_to_bgr_top #(
    parameter int COEFF_FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // luma_left, luma_right, chroma_blue, chroma_red
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // blue_left, green_left, red_left, blue_right, green_right,
                                   // red_right
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import yuv2bgr_pkg::*;

    localparam int SW = COEFF_FRAC_BITS + 11;

    logic                 coef_set_reg;
    pixel_pair_t          in_pair;
    bgr_pair_t            out_pixels;

    logic                 mul_valid, mul_ready;
    logic [7:0]           mul_luma_left, mul_luma_right;
    logic signed [SW-1:0] prod_b, prod_gu, prod_gv, prod_r;

    logic                 sum_valid, sum_ready;
    logic signed [SW-1:0] sum_bl, sum_gl, sum_rl, sum_br, sum_gr, sum_rr;

    logic [1:0]           inflight_reg, inflight_next;
    logic                 s_acc, m_acc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_set_reg <= CSET_SEMI_PLANAR;
        end else if (cfg_valid && cfg_ready) begin
            coef_set_reg <= cfg_data;
        end
    end

    assign in_pair = pixel_pair_t'(s_tdata);
    assign m_tdata = 48'(out_pixels);

    yuv2bgr_mul #(
        .FRAC_BITS (COEFF_FRAC_BITS)
    ) u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .coef_set   (coef_set_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_pair    (in_pair),
        .out_valid  (mul_valid),
        .out_ready  (mul_ready),
        .luma_left  (mul_luma_left),
        .luma_right (mul_luma_right),
        .prod_b     (prod_b),
        .prod_gu    (prod_gu),
        .prod_gv    (prod_gv),
        .prod_r     (prod_r)
    );

    yuv2bgr_sum #(
        .FRAC_BITS (COEFF_FRAC_BITS)
    ) u_sum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (mul_valid),
        .in_ready   (mul_ready),
        .luma_left  (mul_luma_left),
        .luma_right (mul_luma_right),
        .prod_b     (prod_b),
        .prod_gu    (prod_gu),
        .prod_gv    (prod_gv),
        .prod_r     (prod_r),
        .out_valid  (sum_valid),
        .out_ready  (sum_ready),
        .sum_bl     (sum_bl),
        .sum_gl     (sum_gl),
        .sum_rl     (sum_rl),
        .sum_br     (sum_br),
        .sum_gr     (sum_gr),
        .sum_rr     (sum_rr)
    );

    yuv2bgr_clamp #(
        .FRAC_BITS (COEFF_FRAC_BITS)
    ) u_clamp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (sum_valid),
        .in_ready   (sum_ready),
        .sum_bl     (sum_bl),
        .sum_gl     (sum_gl),
        .sum_rl     (sum_rl),
        .sum_br     (sum_br),
        .sum_gr     (sum_gr),
        .sum_rr     (sum_rr),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixels (out_pixels)
    );

    // words in flight, for checking only
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_acc && !m_acc) begin
            inflight_next = inflight_reg + 2'd1;
        end else if (m_acc && !s_acc) begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 2'd0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_empty_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == 2'd0 |-> !m_tvalid)
        else $error("output valid with empty pipe");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> inflight_reg == 2'd3 && !m_tready)
        else $error("input stalled while pipe has room");

    a_full_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == 2'd3 && !m_acc |-> !s_acc)
        else $error("word accepted into full pipe");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == 2'd0 && s_acc ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("word did not reach output in three cycles");

endmodule

/* rtl/yuv2bgr_mul.sv */
// first pipeline stage: coefficient select and chroma products
`timescale 1ns / 1ps

module yuv2bgr_mul #(
    parameter int FRAC_BITS = 14
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           coef_set,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  yuv2bgr_pkg::pixel_pair_t       in_pair,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     luma_left,
    output logic [7:0]                     luma_right,
    output logic signed [FRAC_BITS+10:0]   prod_b,
    output logic signed [FRAC_BITS+10:0]   prod_gu,
    output logic signed [FRAC_BITS+10:0]   prod_gv,
    output logic signed [FRAC_BITS+10:0]   prod_r
);
    import yuv2bgr_pkg::*;

    localparam int KW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 11;

    localparam logic [KW-1:0] KR_S  = KW'(((TT_R_SEMI   << FRAC_BITS) + TT_HALF) / TT_ONE);
    localparam logic [KW-1:0] KGU_S = KW'(((TT_GU_SEMI  << FRAC_BITS) + TT_HALF) / TT_ONE);
    localparam logic [KW-1:0] KGV_S = KW'(((TT_GV_SEMI  << FRAC_BITS) + TT_HALF) / TT_ONE);
    localparam logic [KW-1:0] KB_S  = KW'(((TT_B_SEMI   << FRAC_BITS) + TT_HALF) / TT_ONE);
    localparam logic [KW-1:0] KR_P  = KW'(((TT_R_PLANAR  << FRAC_BITS) + TT_HALF) / TT_ONE);
    localparam logic [KW-1:0] KGU_P = KW'(((TT_GU_PLANAR << FRAC_BITS) + TT_HALF) / TT_ONE);
    localparam logic [KW-1:0] KGV_P = KW'(((TT_GV_PLANAR << FRAC_BITS) + TT_HALF) / TT_ONE);
    localparam logic [KW-1:0] KB_P  = KW'(((TT_B_PLANAR  << FRAC_BITS) + TT_HALF) / TT_ONE);

    logic [KW-1:0]        k_r, k_gu, k_gv, k_b;
    logic signed [SW-1:0] k_r_ext, k_gu_ext, k_gv_ext, k_b_ext;
    logic signed [SW-1:0] d_u_ext, d_v_ext;
    logic                 valid_reg;
    logic                 load;

    always_comb begin
        unique case (coef_set)
            CSET_PLANAR: begin
                k_r  = KR_P;
                k_gu = KGU_P;
                k_gv = KGV_P;
                k_b  = KB_P;
            end
            default: begin
                k_r  = KR_S;
                k_gu = KGU_S;
                k_gv = KGV_S;
                k_b  = KB_S;
            end
        endcase
    end

    // flipping the msb of an offset-128 sample gives the centered value
    assign d_u_ext  = SW'($signed({~in_pair.chroma_blue[7], in_pair.chroma_blue[6:0]}));
    assign d_v_ext  = SW'($signed({~in_pair.chroma_red[7], in_pair.chroma_red[6:0]}));
    assign k_r_ext  = $signed({{(SW-KW){1'b0}}, k_r});
    assign k_gu_ext = $signed({{(SW-KW){1'b0}}, k_gu});
    assign k_gv_ext = $signed({{(SW-KW){1'b0}}, k_gv});
    assign k_b_ext  = $signed({{(SW-KW){1'b0}}, k_b});

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            luma_left  <= in_pair.luma_left;
            luma_right <= in_pair.luma_right;
            prod_b     <= k_b_ext * d_u_ext;
            prod_gu    <= k_gu_ext * d_u_ext;
            prod_gv    <= k_gv_ext * d_v_ext;
            prod_r     <= k_r_ext * d_v_ext;
        end
    end

endmodule

/* rtl/yuv2bgr_sum.sv */
// second pipeline stage: luma plus or minus chroma products for both pixels
`timescale 1ns / 1ps

module yuv2bgr_sum #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    luma_left,
    input  logic [7:0]                    luma_right,
    input  logic signed [FRAC_BITS+10:0]  prod_b,
    input  logic signed [FRAC_BITS+10:0]  prod_gu,
    input  logic signed [FRAC_BITS+10:0]  prod_gv,
    input  logic signed [FRAC_BITS+10:0]  prod_r,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [FRAC_BITS+10:0]  sum_bl,
    output logic signed [FRAC_BITS+10:0]  sum_gl,
    output logic signed [FRAC_BITS+10:0]  sum_rl,
    output logic signed [FRAC_BITS+10:0]  sum_br,
    output logic signed [FRAC_BITS+10:0]  sum_gr,
    output logic signed [FRAC_BITS+10:0]  sum_rr
);
    localparam int SW = FRAC_BITS + 11;

    logic signed [SW-1:0] base_l, base_r, green_off;
    logic                 valid_reg;
    logic                 load;

    assign base_l    = $signed({3'b000, luma_left, {FRAC_BITS{1'b0}}});
    assign base_r    = $signed({3'b000, luma_right, {FRAC_BITS{1'b0}}});
    assign green_off = prod_gu + prod_gv;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sum_bl <= base_l + prod_b;
            sum_gl <= base_l - green_off;
            sum_rl <= base_l + prod_r;
            sum_br <= base_r + prod_b;
            sum_gr <= base_r - green_off;
            sum_rr <= base_r + prod_r;
        end
    end

endmodule

/* rtl/yuv2bgr_clamp.sv */
// third pipeline stage: floor, clamp to 0..255 and output register
`timescale 1ns / 1ps

module yuv2bgr_clamp #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [FRAC_BITS+10:0]  sum_bl,
    input  logic signed [FRAC_BITS+10:0]  sum_gl,
    input  logic signed [FRAC_BITS+10:0]  sum_rl,
    input  logic signed [FRAC_BITS+10:0]  sum_br,
    input  logic signed [FRAC_BITS+10:0]  sum_gr,
    input  logic signed [FRAC_BITS+10:0]  sum_rr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output yuv2bgr_pkg::bgr_pair_t        out_pixels
);
    import yuv2bgr_pkg::*;

    localparam int SW = FRAC_BITS + 11;

    function automatic logic [7:0] floor_clamp(input logic signed [SW-1:0] s);
        logic [7:0] res;
        if (s[SW-1]) begin
            res = 8'd0;
        end else if (|s[SW-2:FRAC_BITS+8]) begin
            res = 8'(CHAN_MAX);
        end else begin
            res = s[FRAC_BITS+7:FRAC_BITS];
        end
        return res;
    endfunction

    bgr_pair_t pix_next;
    logic      valid_reg;
    logic      load;

    always_comb begin
        pix_next.blue_left   = floor_clamp(sum_bl);
        pix_next.green_left  = floor_clamp(sum_gl);
        pix_next.red_left    = floor_clamp(sum_rl);
        pix_next.blue_right  = floor_clamp(sum_br);
        pix_next.green_right = floor_clamp(sum_gr);
        pix_next.red_right   = floor_clamp(sum_rr);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_pixels <= pix_next;
        end
    end

endmodule
